FILE: design/tmen_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tmen_pkg;

    localparam int MAX_NODES     = 1024;
    localparam int MAX_TRIANGLES = 2048;
    localparam int MAX_DEGREE    = 16;

    localparam int NODE_W = 10;
    localparam int TRI_W  = 11;
    localparam int CNT_W  = 12;
    localparam int DEG_W  = 4;
    localparam int LEN_W  = 5;
    localparam int NBR_W  = 12;
    localparam int ENT_AW = NODE_W + DEG_W;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NODE_FULL  = 2'd1,
        STAT_STORE_FULL = 2'd2,
        STAT_RANGE      = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISP,
        ST_CLR,
        ST_LD_CHK,
        ST_LD_RD,
        ST_LD_WR,
        ST_Q_CHK,
        ST_Q_CS,
        ST_Q_L1,
        ST_Q_L0,
        ST_Q_L0W,
        ST_Q_FILL,
        ST_Q_WALK,
        ST_Q_EDGE,
        ST_DONE
    } t_state;

    localparam logic signed [NBR_W-1:0] NO_NBR = '1;

    typedef struct packed {
        logic in_ready;
        logic clr_step;
        logic ld_full;
        logic ld_store;
        logic ld_rd;
        logic ld_wr;
        logic q_range;
        logic q_rd_cs;
        logic q_cap_cs;
        logic q_rd_l1;
        logic q_cap_l1;
        logic q_cap_l0;
        logic q_fill;
        logic q_walk;
        logic q_edge_fin;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  in_valid;
        logic  sweep_last;
        logic  corner_last;
        logic  store_full;
        logic  q_oor;
        logic  fill_done;
        logic  walk_done;
        logic  edge_last;
        logic  out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

FILE: design/tmen_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tmen_in_if;
    import tmen_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [NODE_W-1:0] node_c;
    logic [TRI_W-1:0]  query_triangle;

    modport source (output valid, mode, node_a, node_b, node_c, query_triangle,
                    input ready);
    modport sink   (input valid, mode, node_a, node_b, node_c, query_triangle,
                    output ready);
endinterface

interface tmen_out_if;
    import tmen_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [TRI_W-1:0]        triangle_index;
    logic signed [NBR_W-1:0] neighbour_0;
    logic signed [NBR_W-1:0] neighbour_1;
    logic signed [NBR_W-1:0] neighbour_2;
    logic [1:0]              status;

    modport source (output valid, triangle_index, neighbour_0, neighbour_1,
                    neighbour_2, status, input ready);
    modport sink   (input valid, triangle_index, neighbour_0, neighbour_1,
                    neighbour_2, status, output ready);
endinterface
`default_nettype wire

FILE: design/tmen_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module tmen_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: design/tmen_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tmen_ctrl
    import tmen_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT:   if (i_stat.sweep_last) n_state = ST_IDLE;
            ST_IDLE:   if (i_stat.in_valid) n_state = ST_DISP;
            ST_DISP: begin
                unique case (i_stat.mode)
                    MODE_LOAD:  n_state = ST_LD_CHK;
                    MODE_QUERY: n_state = ST_Q_CHK;
                    MODE_CLEAR: n_state = ST_CLR;
                    MODE_NONE:  n_state = ST_DONE;
                    default:    n_state = ST_DONE;
                endcase
            end
            ST_CLR:    if (i_stat.sweep_last) n_state = ST_DONE;
            ST_LD_CHK: n_state = i_stat.store_full ? ST_DONE : ST_LD_RD;
            ST_LD_RD:  n_state = ST_LD_WR;
            ST_LD_WR:  n_state = i_stat.corner_last ? ST_DONE : ST_LD_RD;
            ST_Q_CHK:  n_state = i_stat.q_oor ? ST_DONE : ST_Q_CS;
            ST_Q_CS:   n_state = ST_Q_L1;
            ST_Q_L1:   n_state = ST_Q_L0;
            ST_Q_L0:   n_state = ST_Q_L0W;
            ST_Q_L0W:  n_state = ST_Q_FILL;
            ST_Q_FILL: if (i_stat.fill_done) n_state = ST_Q_WALK;
            ST_Q_WALK: if (i_stat.walk_done) n_state = ST_Q_EDGE;
            ST_Q_EDGE: n_state = i_stat.edge_last ? ST_DONE : ST_Q_L1;
            ST_DONE:   if (i_stat.out_free) n_state = ST_IDLE;
            default:   n_state = ST_INIT;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_INIT:   o_cmd.clr_step = 1'b1;
            ST_IDLE:   o_cmd.in_ready = 1'b1;
            ST_DISP:   ;
            ST_CLR:    o_cmd.clr_step = 1'b1;
            ST_LD_CHK: begin
                o_cmd.ld_full  = i_stat.store_full;
                o_cmd.ld_store = !i_stat.store_full;
            end
            ST_LD_RD:  o_cmd.ld_rd = 1'b1;
            ST_LD_WR:  o_cmd.ld_wr = 1'b1;
            ST_Q_CHK: begin
                o_cmd.q_range = i_stat.q_oor;
                o_cmd.q_rd_cs = !i_stat.q_oor;
            end
            ST_Q_CS:   o_cmd.q_cap_cs = 1'b1;
            ST_Q_L1:   o_cmd.q_rd_l1 = 1'b1;
            ST_Q_L0:   o_cmd.q_cap_l1 = 1'b1;
            ST_Q_L0W:  o_cmd.q_cap_l0 = 1'b1;
            ST_Q_FILL: o_cmd.q_fill = 1'b1;
            ST_Q_WALK: o_cmd.q_walk = 1'b1;
            ST_Q_EDGE: o_cmd.q_edge_fin = 1'b1;
            ST_DONE:   o_cmd.out_load = i_stat.out_free;
            default:   o_cmd = '0;
        endcase
    end

`ifndef SYNTH
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.clr_step, o_cmd.ld_wr, o_cmd.q_fill, o_cmd.q_walk,
                  o_cmd.out_load, o_cmd.in_ready}))
        else $error("controller issued conflicting commands");
    a_accept_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.in_ready && i_stat.in_valid) |=> (r_state == ST_DISP))
        else $error("transfer not followed by dispatch");
    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == ST_IDLE))
        else $error("result load did not return to idle");
`endif
endmodule
`default_nettype wire

FILE: design/tmen_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module tmen_dp
    import tmen_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  t_dp_cmd      i_cmd,
    output t_dp_stat     o_stat,
    tmen_in_if.sink      i_item,
    tmen_out_if.source   o_result
);
    logic [1:0]              r_mode;
    logic [NODE_W-1:0]       r_node [3];
    logic [TRI_W-1:0]        r_q;
    logic [CNT_W-1:0]        r_count;
    logic [NODE_W-1:0]       r_sweep;
    logic [1:0]              r_corner;
    logic [1:0]              r_edge;
    logic [NODE_W-1:0]       r_cn [3];
    logic [LEN_W-1:0]        r_len1;
    logic [LEN_W-1:0]        r_len0;
    logic [LEN_W-1:0]        r_k;
    logic [LEN_W-1:0]        r_j;
    logic                    r_cap_vld;
    logic [DEG_W-1:0]        r_cap_idx;
    logic [TRI_W-1:0]        r_buf [MAX_DEGREE];
    logic                    r_found;
    logic [TRI_W-1:0]        r_hit;
    logic [TRI_W-1:0]        r_res_idx;
    logic signed [NBR_W-1:0] r_res_nbr [3];
    logic [1:0]              r_res_stat;
    logic                    r_out_vld;
    logic [TRI_W-1:0]        r_out_idx;
    logic signed [NBR_W-1:0] r_out_nbr [3];
    logic [1:0]              r_out_stat;

    logic                    accept;
    logic [NODE_W-1:0]       cur_node;
    logic [NODE_W-1:0]       n0;
    logic [NODE_W-1:0]       n1;
    logic [1:0]              edge_nx;
    logic                    list_full;
    logic                    fill_done;
    logic                    walk_done;
    logic                    hit;

    logic                    len_we;
    logic [NODE_W-1:0]       len_waddr;
    logic [LEN_W-1:0]        len_wdata;
    logic [NODE_W-1:0]       len_raddr;
    logic [LEN_W-1:0]        len_rdata;
    logic                    ent_we;
    logic [ENT_AW-1:0]       ent_raddr;
    logic [TRI_W-1:0]        ent_rdata;
    logic [3*NODE_W-1:0]     cs_rdata;

    assign accept    = i_item.valid && i_cmd.in_ready;
    assign cur_node  = r_node[r_corner];
    assign edge_nx   = (r_edge == 2'd2) ? 2'd0 : r_edge + 2'd1;
    assign n0        = r_cn[r_edge];
    assign n1        = r_cn[edge_nx];
    assign list_full = len_rdata >= LEN_W'(MAX_DEGREE);
    assign fill_done = (r_k == r_len1) && !r_cap_vld;
    assign walk_done = ((r_j == r_len0) || r_found) && !r_cap_vld;

    // membership of the walked entry in the buffered second list
    always_comb begin
        hit = 1'b0;
        for (int m = 0; m < MAX_DEGREE; m++) begin
            if ((LEN_W'(m) < r_len1) && (r_buf[m] == ent_rdata)) begin
                hit = 1'b1;
            end
        end
    end

    assign len_we    = i_cmd.clr_step || (i_cmd.ld_wr && !list_full);
    assign len_waddr = i_cmd.clr_step ? r_sweep : cur_node;
    assign len_wdata = i_cmd.clr_step ? '0 : len_rdata + LEN_W'(1);
    assign len_raddr = i_cmd.ld_rd ? cur_node : (i_cmd.q_rd_l1 ? n1 : n0);
    assign ent_we    = i_cmd.ld_wr && !list_full;
    assign ent_raddr = i_cmd.q_walk ? {n0, r_j[DEG_W-1:0]} : {n1, r_k[DEG_W-1:0]};

    tmen_ram #(.WIDTH(3*NODE_W), .DEPTH(MAX_TRIANGLES)) u_corner_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ld_store),
        .i_waddr (r_count[TRI_W-1:0]),
        .i_wdata ({r_node[2], r_node[1], r_node[0]}),
        .i_raddr (r_q),
        .o_rdata (cs_rdata)
    );

    tmen_ram #(.WIDTH(LEN_W), .DEPTH(MAX_NODES)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_raddr (len_raddr),
        .o_rdata (len_rdata)
    );

    tmen_ram #(.WIDTH(TRI_W), .DEPTH(MAX_NODES*MAX_DEGREE)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr ({cur_node, len_rdata[DEG_W-1:0]}),
        .i_wdata (r_count[TRI_W-1:0]),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_sweep   <= '0;
            r_corner  <= '0;
            r_edge    <= '0;
            r_k       <= '0;
            r_j       <= '0;
            r_cap_vld <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_sweep  <= '0;
                r_corner <= '0;
                r_edge   <= '0;
            end
            if (i_cmd.clr_step) begin
                r_sweep <= r_sweep + NODE_W'(1);
                if (r_sweep == NODE_W'(MAX_NODES - 1)) begin
                    r_count <= '0;
                end
            end
            if (i_cmd.ld_wr) begin
                r_corner <= r_corner + 2'd1;
                if (r_corner == 2'd2) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.q_cap_l0) begin
                r_k       <= '0;
                r_cap_vld <= 1'b0;
                r_found   <= 1'b0;
            end
            if (i_cmd.q_fill) begin
                r_cap_vld <= r_k < r_len1;
                if (r_k < r_len1) begin
                    r_k <= r_k + LEN_W'(1);
                end
                if (fill_done) begin
                    r_j <= '0;
                end
            end
            if (i_cmd.q_walk) begin
                r_cap_vld <= (r_j < r_len0) && !r_found;
                if ((r_j < r_len0) && !r_found) begin
                    r_j <= r_j + LEN_W'(1);
                end
                if (r_cap_vld && !r_found && (ent_rdata != r_q) && hit) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.q_edge_fin) begin
                r_edge <= r_edge + 2'd1;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode       <= i_item.mode;
            r_node[0]    <= i_item.node_a;
            r_node[1]    <= i_item.node_b;
            r_node[2]    <= i_item.node_c;
            r_q          <= i_item.query_triangle;
            r_res_idx    <= '0;
            r_res_nbr[0] <= NO_NBR;
            r_res_nbr[1] <= NO_NBR;
            r_res_nbr[2] <= NO_NBR;
            r_res_stat   <= STAT_OK;
        end
        if (i_cmd.ld_full) begin
            r_res_stat <= STAT_STORE_FULL;
        end
        if (i_cmd.ld_store) begin
            r_res_idx <= r_count[TRI_W-1:0];
        end
        if (i_cmd.ld_wr && list_full) begin
            r_res_stat <= STAT_NODE_FULL;
        end
        if (i_cmd.q_range || i_cmd.q_cap_cs) begin
            r_res_idx <= r_q;
        end
        if (i_cmd.q_range) begin
            r_res_stat <= STAT_RANGE;
        end
        if (i_cmd.q_cap_cs) begin
            r_cn[0] <= cs_rdata[NODE_W-1:0];
            r_cn[1] <= cs_rdata[2*NODE_W-1:NODE_W];
            r_cn[2] <= cs_rdata[3*NODE_W-1:2*NODE_W];
        end
        if (i_cmd.q_cap_l1) begin
            r_len1 <= len_rdata;
        end
        if (i_cmd.q_cap_l0) begin
            r_len0 <= len_rdata;
        end
        if (i_cmd.q_fill && r_cap_vld) begin
            r_buf[r_cap_idx] <= ent_rdata;
        end
        if ((i_cmd.q_fill || i_cmd.q_walk) && r_k < r_len1) begin
            r_cap_idx <= r_k[DEG_W-1:0];
        end
        if (i_cmd.q_walk && r_cap_vld && !r_found && (ent_rdata != r_q) && hit) begin
            r_hit <= ent_rdata;
        end
        if (i_cmd.q_edge_fin) begin
            r_res_nbr[r_edge] <= r_found ? $signed({1'b0, r_hit}) : NO_NBR;
        end
        if (i_cmd.out_load) begin
            r_out_idx    <= r_res_idx;
            r_out_nbr[0] <= r_res_nbr[0];
            r_out_nbr[1] <= r_res_nbr[1];
            r_out_nbr[2] <= r_res_nbr[2];
            r_out_stat   <= r_res_stat;
        end
    end

    assign i_item.ready            = i_cmd.in_ready;
    assign o_result.valid          = r_out_vld;
    assign o_result.triangle_index = r_out_idx;
    assign o_result.neighbour_0    = r_out_nbr[0];
    assign o_result.neighbour_1    = r_out_nbr[1];
    assign o_result.neighbour_2    = r_out_nbr[2];
    assign o_result.status         = r_out_stat;

    assign o_stat.mode        = t_mode'(r_mode);
    assign o_stat.in_valid    = i_item.valid;
    assign o_stat.sweep_last  = r_sweep == NODE_W'(MAX_NODES - 1);
    assign o_stat.corner_last = r_corner == 2'd2;
    assign o_stat.store_full  = r_count >= CNT_W'(MAX_TRIANGLES);
    assign o_stat.q_oor       = {1'b0, r_q} >= r_count;
    assign o_stat.fill_done   = fill_done;
    assign o_stat.walk_done   = walk_done;
    assign o_stat.edge_last   = r_edge == 2'd2;
    assign o_stat.out_free    = !r_out_vld || o_result.ready;

`ifndef SYNTH
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_TRIANGLES))
        else $error("triangle count beyond store depth");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.q_walk |-> (r_j <= LEN_W'(MAX_DEGREE)))
        else $error("list walk past maximum degree");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.q_fill |-> (r_k <= LEN_W'(MAX_DEGREE)))
        else $error("list fill past maximum degree");
`endif
endmodule
`default_nettype wire

FILE: design/triangle_mesh_edge_neighbours.sv
// a query walks, for each edge, the lists of its two nodes, so its time grows with
//   the two node list lengths; each list memory has one registered read port
// one item at a time; the result register frees the input side once loaded
// reset is synchronous active low; afterwards a pass over every node zeroes the
//   node list lengths and no item is accepted until it ends
`timescale 1ns / 1ps
`default_nettype none
module triangle_mesh_edge_neighbours
    import tmen_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    tmen_in_if.sink    i_item,
    tmen_out_if.source o_result
);
    t_dp_cmd  cmd;
    t_dp_stat stat;

    tmen_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    tmen_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .i_item   (i_item),
        .o_result (o_result)
    );
endmodule
`default_nettype wire

FILE: sim/mesh_adjacency_monitor.sv
`timescale 1ns / 1ps
module mesh_adjacency_monitor
    import tmen_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    tmen_in_if         i_item,
    tmen_out_if        i_result,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct {
        logic [TRI_W-1:0]        tri_idx;
        logic signed [NBR_W-1:0] nbr [3];
        t_status                 status;
    } t_adjacency;

    logic [NODE_W-1:0] corners [MAX_TRIANGLES][3];
    int                tri_count;
    int                list_len [MAX_NODES];
    logic [TRI_W-1:0]  list_tri [MAX_NODES][MAX_DEGREE];
    t_adjacency        expected_q [$];

    // first entry of n0's list, other than t, that also sits in n1's list
    function automatic logic signed [NBR_W-1:0] across_edge(int t, int n0, int n1);
        for (int j = 0; j < list_len[n0]; j++) begin
            if (list_tri[n0][j] != t) begin
                for (int k = 0; k < list_len[n1]; k++) begin
                    if (list_tri[n1][k] == list_tri[n0][j])
                        return {1'b0, list_tri[n0][j]};
                end
            end
        end
        return NO_NBR;
    endfunction

    function automatic t_adjacency predict_adjacency(t_mode mode, logic [NODE_W-1:0] na,
                                                     logic [NODE_W-1:0] nb,
                                                     logic [NODE_W-1:0] nc,
                                                     logic [TRI_W-1:0] qt);
        t_adjacency r;
        logic [NODE_W-1:0] nodes [3];
        int n;
        r.tri_idx = '0;
        r.nbr[0] = NO_NBR;
        r.nbr[1] = NO_NBR;
        r.nbr[2] = NO_NBR;
        r.status = STAT_OK;
        nodes[0] = na;
        nodes[1] = nb;
        nodes[2] = nc;
        case (mode)
            MODE_LOAD: begin
                if (tri_count >= MAX_TRIANGLES) begin
                    r.status = STAT_STORE_FULL;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        n = nodes[i];
                        corners[tri_count][i] = nodes[i];
                        if (list_len[n] >= MAX_DEGREE) begin
                            r.status = STAT_NODE_FULL;
                        end else begin
                            list_tri[n][list_len[n]] = tri_count[TRI_W-1:0];
                            list_len[n]++;
                        end
                    end
                    r.tri_idx = tri_count[TRI_W-1:0];
                    tri_count++;
                end
            end
            MODE_QUERY: begin
                r.tri_idx = qt;
                if (qt >= tri_count) begin
                    r.status = STAT_RANGE;
                end else begin
                    for (int i = 0; i < 3; i++)
                        r.nbr[i] = across_edge(qt, corners[qt][i], corners[qt][(i + 1) % 3]);
                end
            end
            MODE_CLEAR: begin
                tri_count = 0;
                for (int i = 0; i < MAX_NODES; i++)
                    list_len[i] = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        tri_count = 0;
        for (int i = 0; i < MAX_NODES; i++)
            list_len[i] = 0;
    end

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_adjacency e;
        if (i_rst_n) begin
            // retire a result before predicting the next transfer
            if (i_result.valid && i_result.ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result idx=%0d", $time, i_result.triangle_index);
                    o_fail_count++;
                end else begin
                    e = expected_q.pop_front();
                    if (i_result.triangle_index !== e.tri_idx ||
                        i_result.neighbour_0 !== e.nbr[0] ||
                        i_result.neighbour_1 !== e.nbr[1] ||
                        i_result.neighbour_2 !== e.nbr[2] ||
                        i_result.status !== e.status) begin
                        $display("%0t: mismatch expected idx=%0d nbr=%0d,%0d,%0d st=%0d",
                                 $time, e.tri_idx, e.nbr[0], e.nbr[1], e.nbr[2], e.status);
                        $display("%0t:          actual   idx=%0d nbr=%0d,%0d,%0d st=%0d",
                                 $time, i_result.triangle_index, i_result.neighbour_0,
                                 i_result.neighbour_1, i_result.neighbour_2, i_result.status);
                        o_fail_count++;
                    end
                end
            end
            if (i_item.valid && i_item.ready)
                expected_q.push_back(predict_adjacency(t_mode'(i_item.mode), i_item.node_a,
                                                       i_item.node_b, i_item.node_c,
                                                       i_item.query_triangle));
        end
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import tmen_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic idle_on;
    int   fail_count;
    int   pending;
    int   loaded;

    tmen_in_if  u_item_if ();
    tmen_out_if u_result_if ();

    triangle_mesh_edge_neighbours u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (u_item_if),
        .o_result (u_result_if)
    );

    mesh_adjacency_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (u_item_if),
        .i_result     (u_result_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("FAIL triangle_mesh_edge_neighbours");
        $finish;
    end

    always @(negedge i_clk)
        u_result_if.ready <= idle_on ? ($urandom % 100 >= 19) : 1'b1;

    task automatic send_item(t_mode mode, logic [NODE_W-1:0] na, logic [NODE_W-1:0] nb,
                             logic [NODE_W-1:0] nc, logic [TRI_W-1:0] qt);
        while (idle_on && $urandom % 100 < 19) begin
            u_item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        u_item_if.valid          <= 1'b1;
        u_item_if.mode           <= mode;
        u_item_if.node_a         <= na;
        u_item_if.node_b         <= nb;
        u_item_if.node_c         <= nc;
        u_item_if.query_triangle <= qt;
        do @(posedge i_clk); while (!u_item_if.ready);
        @(negedge i_clk);
        if (mode == MODE_LOAD && loaded < MAX_TRIANGLES) loaded++;
        if (mode == MODE_CLEAR) loaded = 0;
    endtask

    function automatic logic [NODE_W-1:0] pick_node(int base);
        return ($urandom % 10 == 0) ? NODE_W'($urandom) : NODE_W'(base + $urandom_range(0, 23));
    endfunction

    initial begin
        int base;
        int r;
        logic [TRI_W-1:0] qt;
        i_rst_n = 1'b0;
        idle_on = 1'b0;
        loaded = 0;
        u_item_if.valid = 1'b0;
        u_item_if.mode = MODE_NONE;
        u_item_if.node_a = '0;
        u_item_if.node_b = '0;
        u_item_if.node_c = '0;
        u_item_if.query_triangle = '0;
        u_result_if.ready = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed corners of the behavior
        send_item(MODE_QUERY, 0, 0, 0, 0);
        send_item(MODE_LOAD, 0, 1, 2, 0);
        send_item(MODE_LOAD, 1, 2, 3, 0);
        send_item(MODE_LOAD, 2, 0, 1, 0);
        send_item(MODE_LOAD, 1023, 1023, 1023, 0);
        send_item(MODE_LOAD, 0, 1023, 1023, 0);
        for (int i = 0; i < 5; i++)
            send_item(MODE_QUERY, 0, 0, 0, TRI_W'(i));
        send_item(MODE_QUERY, 0, 0, 0, 2047);
        send_item(MODE_NONE, 1023, 1023, 1023, 2047);
        send_item(MODE_CLEAR, 0, 0, 0, 0);
        send_item(MODE_QUERY, 0, 0, 0, 0);
        for (int i = 0; i < 17; i++)
            send_item(MODE_LOAD, 5, 6, NODE_W'(7 + i), 0);
        send_item(MODE_QUERY, 0, 0, 0, 16);

        // random mix, mostly loads into a small neighborhood and in-range queries
        idle_on = 1'b1;
        base = 0;
        for (int i = 0; i < 1500; i++) begin
            if (i % 500 == 0) idle_on = 1'b0;
            if (i % 500 == 150) idle_on = 1'b1;
            if (i == 750) begin
                u_item_if.valid <= 1'b0;
                wait (pending == 0);
                @(negedge i_clk);
            end
            r = $urandom % 100;
            if (r < 45) begin
                send_item(MODE_LOAD, pick_node(base), pick_node(base), pick_node(base),
                          TRI_W'($urandom));
            end else if (r < 93) begin
                qt = (loaded > 0 && r < 88) ? TRI_W'($urandom_range(0, loaded - 1))
                                            : TRI_W'($urandom);
                send_item(MODE_QUERY, NODE_W'($urandom), NODE_W'($urandom),
                          NODE_W'($urandom), qt);
            end else if (r < 96) begin
                send_item(MODE_NONE, NODE_W'($urandom), NODE_W'($urandom),
                          NODE_W'($urandom), TRI_W'($urandom));
            end else if (r < 97) begin
                send_item(MODE_CLEAR, NODE_W'($urandom), NODE_W'($urandom),
                          NODE_W'($urandom), TRI_W'($urandom));
                base = $urandom_range(0, 1000);
            end else begin
                base = $urandom_range(0, 1000);
            end
        end

        send_item(MODE_QUERY, 0, 0, 0, 2047);
        send_item(MODE_QUERY, 0, 0, 0, TRI_W'($urandom));

        u_item_if.valid <= 1'b0;
        wait (pending == 0);
        repeat (150) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS triangle_mesh_edge_neighbours");
        else
            $display("FAIL triangle_mesh_edge_neighbours");
        $finish;
    end

endmodule
